// ===== src/grc_pkg.sv =====
// Shared constants and types for the grid region counter.
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_VALUE_WIDTH = 16;

    // Configuration port layout and register indexes.
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    // Size that both size registers take at reset, before clamping to the maximum.
    localparam int SIZE_RESET = 64;

    // Width of the region count result.
    localparam int COUNT_W = 13;

    // One result beat from the fill engine.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage : grc_pkg

`default_nettype wire

// ===== src/grc_grid_store.sv =====
// Grid value memory: one write port for loading, one registered read port for the fill.
`timescale 1ns / 1ps
`default_nettype none

module grc_grid_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_wa,
    input  wire logic [DW-1:0] i_wd,
    input  wire logic [AW-1:0] i_ra,
    output logic      [DW-1:0] o_rd
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;

    // Write from the loader.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // Registered read for the fill engine.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule : grc_grid_store

`default_nettype wire

// ===== src/grc_fill_engine.sv =====
// Sequencer that clears the visited map, scans the grid and flood-fills each new region.
`timescale 1ns / 1ps
`default_nettype none

module grc_fill_engine #(
    parameter int MAX_ROWS    = grc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = grc_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = grc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_go,
    input  wire logic [$clog2(MAX_ROWS + 1)-1:0]          i_rows,
    input  wire logic [$clog2(MAX_COLS + 1)-1:0]          i_cols,
    input  wire logic [$clog2(MAX_ROWS * MAX_COLS + 1)-1:0] i_total,
    output logic [((MAX_ROWS * MAX_COLS > 1) ?
                   $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0]  o_grid_ra,
    input  wire logic [VALUE_WIDTH-1:0]                   i_grid_rd,
    output logic                                          o_busy,
    output grc_pkg::t_result                              o_result
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TW    = $clog2(CELLS + 1);
    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int CSW   = $clog2(MAX_COLS + 1);
    localparam int RSW1  = RSW + 1;
    localparam int CSW1  = CSW + 1;
    localparam int SEW   = AW + RSW + CSW;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_POPW  = 4'd5;
    localparam logic [3:0] S_NB    = 4'd6;
    localparam logic [3:0] S_NCHK  = 4'd7;

    // Neighbor directions, in the order they are tried.
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    logic [3:0]                 r_state, n_state;
    logic [AW-1:0]              r_idx, n_idx;
    logic [RSW-1:0]             r_srow, n_srow;
    logic [CSW-1:0]             r_scol, n_scol;
    logic [TW-1:0]              r_top, n_top;
    logic [1:0]                 r_dir, n_dir;
    logic [grc_pkg::COUNT_W-1:0] r_count, n_count;
    grc_pkg::t_result           r_res, n_res;

    // Payload registers of the fill.
    logic [VALUE_WIDTH-1:0] r_val;
    logic [AW-1:0]          r_cur_lin, r_nb_lin;
    logic [RSW-1:0]         r_cur_row, r_nb_row;
    logic [CSW-1:0]         r_cur_col, r_nb_col;

    // Memories: visited map and fill stack.
    logic           r_vis [CELLS];
    logic [SEW-1:0] r_stk [CELLS];
    logic           r_vis_rd;
    logic [SEW-1:0] r_stk_rd;

    logic           vis_we, vis_wd;
    logic [AW-1:0]  vis_wa, mem_ra;
    logic           stk_we;
    logic [AW-1:0]  stk_wa, stk_ra;
    logic [SEW-1:0] stk_wd;

    logic           nb_ok;
    logic [AW-1:0]  nb_lin;
    logic [RSW-1:0] nb_row;
    logic [CSW-1:0] nb_col;
    logic [TW-1:0]  idx_next;
    logic           scan_last;
    logic           adv;
    logic           nb_match;

    // End of the scan range: the index after this one equals the cell count.
    assign idx_next  = TW'(r_idx) + TW'(1);
    assign scan_last = (idx_next == i_total);
    assign nb_match  = !r_vis_rd && (i_grid_rd == r_val);

    // Neighbor of the current cell in the direction under test, with its bound check.
    always_comb begin
        nb_ok  = 1'b0;
        nb_lin = r_cur_lin;
        nb_row = r_cur_row;
        nb_col = r_cur_col;
        unique case (r_dir)
            DIR_DOWN: begin
                nb_ok  = (RSW1'(r_cur_row) + RSW1'(1)) < RSW1'(i_rows);
                nb_lin = r_cur_lin + AW'(i_cols);
                nb_row = r_cur_row + RSW'(1);
            end
            DIR_RIGHT: begin
                nb_ok  = (CSW1'(r_cur_col) + CSW1'(1)) < CSW1'(i_cols);
                nb_lin = r_cur_lin + AW'(1);
                nb_col = r_cur_col + CSW'(1);
            end
            DIR_UP: begin
                nb_ok  = (r_cur_row != '0);
                nb_lin = r_cur_lin - AW'(i_cols);
                nb_row = r_cur_row - RSW'(1);
            end
            DIR_LEFT: begin
                nb_ok  = (r_cur_col != '0);
                nb_lin = r_cur_lin - AW'(1);
                nb_col = r_cur_col - CSW'(1);
            end
        endcase
    end

    // Shared read address for the grid and the visited map.
    assign mem_ra    = (r_state == S_NB) ? nb_lin : r_idx;
    assign o_grid_ra = mem_ra;
    assign stk_ra    = AW'(r_top - TW'(1));

    // Sequencer next state and memory write strobes.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_srow      = r_srow;
        n_scol      = r_scol;
        n_top       = r_top;
        n_dir       = r_dir;
        n_count     = r_count;
        n_res.valid = 1'b0;
        n_res.count = r_res.count;
        vis_we      = 1'b0;
        vis_wd      = 1'b0;
        vis_wa      = r_idx;
        stk_we      = 1'b0;
        stk_wa      = AW'(r_top);
        stk_wd      = {r_idx, r_srow, r_scol};
        adv         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_CLEAR;
                    n_idx   = '0;
                end
            end
            S_CLEAR: begin
                vis_we = 1'b1;
                if (scan_last) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_srow  = '0;
                    n_scol  = '0;
                    n_count = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_SCAN: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_vis_rd) begin
                    adv = 1'b1;
                end else begin
                    // New region: mark the seed and push it.
                    vis_we  = 1'b1;
                    vis_wd  = 1'b1;
                    stk_we  = 1'b1;
                    n_top   = TW'(1);
                    n_count = r_count + grc_pkg::COUNT_W'(1);
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_top == '0) begin
                    adv = 1'b1;
                end else begin
                    n_top   = r_top - TW'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_dir   = DIR_DOWN;
                n_state = S_NB;
            end
            S_NB: begin
                if (nb_ok) begin
                    n_state = S_NCHK;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = S_POP;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            S_NCHK: begin
                if (nb_match) begin
                    vis_we = 1'b1;
                    vis_wd = 1'b1;
                    vis_wa = r_nb_lin;
                    stk_we = 1'b1;
                    stk_wd = {r_nb_lin, r_nb_row, r_nb_col};
                    n_top  = r_top + TW'(1);
                end
                if (r_dir == DIR_LEFT) begin
                    n_state = S_POP;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_NB;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Move the scan to the next cell, or finish and report the count.
        if (adv) begin
            if (scan_last) begin
                n_state     = S_IDLE;
                n_res.valid = 1'b1;
                n_res.count = r_count;
            end else begin
                n_idx   = r_idx + AW'(1);
                n_state = S_SCAN;
                if ((CSW1'(r_scol) + CSW1'(1)) == CSW1'(i_cols)) begin
                    n_scol = '0;
                    n_srow = r_srow + RSW'(1);
                end else begin
                    n_scol = r_scol + CSW'(1);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_srow  <= '0;
            r_scol  <= '0;
            r_top   <= '0;
            r_dir   <= DIR_DOWN;
            r_count <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_srow  <= n_srow;
            r_scol  <= n_scol;
            r_top   <= n_top;
            r_dir   <= n_dir;
            r_count <= n_count;
            r_res   <= n_res;
        end
    end

    // Payload captures: seed value, popped cell and neighbor under test.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCHK && !r_vis_rd) begin
            r_val <= i_grid_rd;
        end
        if (r_state == S_POPW) begin
            {r_cur_lin, r_cur_row, r_cur_col} <= r_stk_rd;
        end
        if (r_state == S_NB) begin
            r_nb_lin <= nb_lin;
            r_nb_row <= nb_row;
            r_nb_col <= nb_col;
        end
    end

    // Visited map: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis[vis_wa] <= vis_wd;
        end
        r_vis_rd <= r_vis[mem_ra];
    end

    // Fill stack: push at the top, registered read of the entry below it.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk[stk_ra];
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_res;

    // A count is only started while the engine is idle.
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_go)
        else $error("count started while the fill engine was busy");

    // Each cell is pushed at most once, so the stack never holds more than the grid.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= i_total)
        else $error("fill stack grew past the cell count");

    // A popped cell always lies inside the grid.
    a_cur_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB) |-> ((RSW1'(r_cur_row) < RSW1'(i_rows)) &&
                               (CSW1'(r_cur_col) < CSW1'(i_cols))))
        else $error("popped cell outside the grid");

    // The result strobe lasts one cycle and leaves the engine idle.
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.valid |-> (r_state == S_IDLE) ##1 !r_res.valid)
        else $error("result strobe longer than one cycle");

endmodule : grc_fill_engine

`default_nettype wire

// ===== src/grid_region_counter.sv =====
// Top level of the grid region counter: configuration, cell loading and result output.
`timescale 1ns / 1ps
`default_nettype none

// Counts the 4-connected regions of equal cell value in a grid of num_rows by
// num_cols cells. Cells arrive one beat per cycle in raster order while o_busy
// is low; a beat with i_last_cell set stores that cell if it is in range and
// starts the count, and cells beyond rows*cols are dropped. o_busy then stays
// high until the count is done. The count first clears the visited map, then
// scans each cell, and for each cell of a region pops it, tries each neighbor
// direction and checks each in-grid neighbor; the single visited-map port and
// the one-neighbor-per-step fill loop set its speed. The count appears on
// o_region_count, marked by o_valid for exactly one cycle, and cannot be held
// off by the receiver. The user must write the size registers only while
// o_busy is low; the block does not enforce this. A size of zero is taken as
// one and a size above the maximum as the maximum.
module grid_region_counter #(
    parameter int MAX_ROWS    = grc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = grc_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = grc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [grc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [VALUE_WIDTH-1:0]           i_cell_value,
    input  wire logic                             i_last_cell,
    output logic                                  o_valid,
    output logic [grc_pkg::COUNT_W-1:0]           o_region_count
);

    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TW       = $clog2(CELLS + 1);
    localparam int RSW      = $clog2(MAX_ROWS + 1);
    localparam int CSW      = $clog2(MAX_COLS + 1);
    localparam int PW       = RSW + CSW;
    localparam int ROWS_RST = (grc_pkg::SIZE_RESET > MAX_ROWS) ? MAX_ROWS : grc_pkg::SIZE_RESET;
    localparam int COLS_RST = (grc_pkg::SIZE_RESET > MAX_COLS) ? MAX_COLS : grc_pkg::SIZE_RESET;

    logic [RSW-1:0]   r_rows, n_rows;
    logic [CSW-1:0]   r_cols, n_cols;
    logic [TW-1:0]    r_load_pos, n_load_pos;
    logic [RSW-1:0]   rows_wr;
    logic [CSW-1:0]   cols_wr;
    logic [PW-1:0]    prod;
    logic [TW-1:0]    total;
    logic             accept;
    logic             load_we;
    logic             go;
    logic             busy;
    logic [AW-1:0]    grid_ra;
    logic [VALUE_WIDTH-1:0] grid_rd;
    grc_pkg::t_result result;

    // Clamp written sizes into 1..maximum.
    always_comb begin
        if (i_cfg_data == '0) begin
            rows_wr = RSW'(1);
            cols_wr = CSW'(1);
        end else begin
            rows_wr = (int'(i_cfg_data) > MAX_ROWS) ? RSW'(MAX_ROWS) : RSW'(i_cfg_data);
            cols_wr = (int'(i_cfg_data) > MAX_COLS) ? CSW'(MAX_COLS) : CSW'(i_cfg_data);
        end
    end

    // Register decode.
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                grc_pkg::REG_NUM_ROWS: n_rows = rows_wr;
                grc_pkg::REG_NUM_COLS: n_cols = cols_wr;
            endcase
        end
    end

    // Number of cells in use.
    assign prod  = PW'(r_rows) * PW'(r_cols);
    assign total = TW'(prod);

    // Input beat handling: store while in range, restart after the last cell.
    assign accept  = i_start && !busy;
    assign load_we = accept && (r_load_pos < total);
    assign go      = accept && i_last_cell;

    always_comb begin
        n_load_pos = r_load_pos;
        if (go) begin
            n_load_pos = '0;
        end else if (load_we) begin
            n_load_pos = r_load_pos + TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= RSW'(ROWS_RST);
            r_cols     <= CSW'(COLS_RST);
            r_load_pos <= '0;
        end else begin
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_load_pos <= n_load_pos;
        end
    end

    grc_grid_store #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (VALUE_WIDTH)
    ) u_grid_store (
        .i_clk (i_clk),
        .i_we  (load_we),
        .i_wa  (AW'(r_load_pos)),
        .i_wd  (i_cell_value),
        .i_ra  (grid_ra),
        .o_rd  (grid_rd)
    );

    grc_fill_engine #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_fill_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_rows    (r_rows),
        .i_cols    (r_cols),
        .i_total   (total),
        .o_grid_ra (grid_ra),
        .i_grid_rd (grid_rd),
        .o_busy    (busy),
        .o_result  (result)
    );

    assign o_busy         = busy;
    assign o_valid        = result.valid;
    assign o_region_count = result.count;

endmodule : grid_region_counter

`default_nettype wire
